// ===== hdl/tkfr_pkg.sv =====
// Shared types and constants for the top-K frequency ranking block.
// Used by tkfr_queue, tkfr_engine and top_k_frequency_ranking; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tkfr_pkg;

   localparam int DATA_W = 32;
   localparam int POS_W  = 3;
   localparam int KEEP_W = 4;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 4'd5;

   typedef struct packed {
      logic [DATA_W-1:0] doc_id;
      logic [DATA_W-1:0] count;
   } item_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_UPD,
      ST_EMIT
   } eng_state_type;

endpackage

`default_nettype wire

// ===== hdl/tkfr_queue.sv =====
// Front end: accepts requests into a two-entry queue ahead of the ranking engine.
// Depends on tkfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tkfr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  tkfr_pkg::item_type     push_item,
   output logic                   head_valid,
   output tkfr_pkg::item_type     head_item,
   input  wire logic              pop
);

   tkfr_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] used_ff, used_in;
   logic       do_push;
   logic       do_pop;

   assign full       = (used_ff == 2'd2);
   assign head_valid = (used_ff != 2'd0);
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      used_in   = used_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         used_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         used_ff   <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/tkfr_engine.sv =====
// Back end: holds the ranked list, applies one request at a time and streams
// the list out through a registered result stage. Depends on tkfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tkfr_engine #(
   parameter int MAX_KEEP = 8
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [$clog2(MAX_KEEP+1)-1:0] keep,
   input  wire logic                         head_valid,
   input  tkfr_pkg::item_type                head_item,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [tkfr_pkg::DATA_W-1:0]       rsp_rank_doc,
   output logic [tkfr_pkg::DATA_W-1:0]       rsp_rank_count,
   output logic [tkfr_pkg::POS_W-1:0]        rsp_position,
   output logic                              rsp_applied,
   output logic                              rsp_last
);

   localparam int CNT_W = $clog2(MAX_KEEP + 1);
   localparam int IDX_W = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

   tkfr_pkg::eng_state_type state_ff, state_in;

   logic [tkfr_pkg::DATA_W-1:0] ids_ff    [MAX_KEEP];
   logic [tkfr_pkg::DATA_W-1:0] counts_ff [MAX_KEEP];
   logic [tkfr_pkg::DATA_W-1:0] ids_in    [MAX_KEEP];
   logic [tkfr_pkg::DATA_W-1:0] counts_in [MAX_KEEP];
   logic [CNT_W-1:0]            fill_ff, fill_in;

   tkfr_pkg::item_type cur_ff;
   logic [MAX_KEEP-1:0] id_eq_ff, gt_ff, eq_ff;
   logic [MAX_KEEP-1:0] id_eq_in, gt_in, eq_in;

   logic             applied_ff, applied_in;
   logic [CNT_W-1:0] emit_ff, emit_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tkfr_pkg::DATA_W-1:0] rsp_doc_ff, rsp_cnt_ff;
   logic [tkfr_pkg::POS_W-1:0]  rsp_pos_ff;
   logic                        rsp_applied_ff, rsp_last_ff;

   logic out_free;
   logic cmp_en, upd_en, load_out;
   logic emit_last;

   // update decode
   logic                found;
   logic [CNT_W-1:0]    f_idx;
   logic [CNT_W-1:0]    split;
   logic [CNT_W-1:0]    ins_pos;
   logic [MAX_KEEP-1:0] ahead;
   logic                last_gt;
   logic                consider;
   logic [CNT_W:0]      new_len;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_last = ((emit_ff + CNT_W'(1)) == fill_ff);

   always_comb begin
      for (int i = 0; i < MAX_KEEP; i++) begin
         id_eq_in[i] = (ids_ff[i] == cur_ff.doc_id);
         gt_in[i]    = (cur_ff.count > counts_ff[i]);
         eq_in[i]    = (cur_ff.count == counts_ff[i]);
      end
   end

   always_comb begin
      found   = 1'b0;
      f_idx   = '0;
      last_gt = 1'b0;
      for (int i = MAX_KEEP - 1; i >= 0; i--) begin
         if (id_eq_ff[i] && (CNT_W'(i) < fill_ff)) begin
            found = 1'b1;
            f_idx = CNT_W'(i);
         end
         if ((CNT_W'(i) + CNT_W'(1)) == fill_ff) begin
            last_gt = gt_ff[i];
         end
      end
      split = found ? f_idx : fill_ff;
      for (int i = 0; i < MAX_KEEP; i++) begin
         ahead[i] = (CNT_W'(i) < fill_ff) && !(found && (CNT_W'(i) == f_idx))
                    && ((!gt_ff[i] && !eq_ff[i]) || (eq_ff[i] && (CNT_W'(i) < split)));
      end
      ins_pos = '0;
      for (int i = 0; i < MAX_KEEP; i++) begin
         ins_pos = ins_pos + CNT_W'(ahead[i]);
      end
      consider = (fill_ff < keep) || ((fill_ff != '0) && last_gt);
      new_len  = found ? {1'b0, fill_ff} : ({1'b0, fill_ff} + (CNT_W+1)'(1));
   end

   // rebuild: entries ahead of the insert point shift from behind the removed
   // slot, entries after it shift from in front of it
   always_comb begin
      for (int j = 0; j < MAX_KEEP; j++) begin
         if (CNT_W'(j) < ins_pos) begin
            if ((CNT_W'(j) < split) || (j + 1 >= MAX_KEEP)) begin
               ids_in[j]    = ids_ff[j];
               counts_in[j] = counts_ff[j];
            end else begin
               ids_in[j]    = ids_ff[(j + 1) % MAX_KEEP];
               counts_in[j] = counts_ff[(j + 1) % MAX_KEEP];
            end
         end else if (CNT_W'(j) == ins_pos) begin
            ids_in[j]    = cur_ff.doc_id;
            counts_in[j] = cur_ff.count;
         end else if ((j > 0) && ((CNT_W'(j) - CNT_W'(1)) < split)) begin
            ids_in[j]    = ids_ff[(j + MAX_KEEP - 1) % MAX_KEEP];
            counts_in[j] = counts_ff[(j + MAX_KEEP - 1) % MAX_KEEP];
         end else begin
            ids_in[j]    = ids_ff[j];
            counts_in[j] = counts_ff[j];
         end
      end
      if (new_len > {1'b0, keep}) begin
         fill_in = keep;
      end else begin
         fill_in = new_len[CNT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tkfr_pkg::ST_IDLE: begin
            if (head_valid) begin
               state_in = tkfr_pkg::ST_CMP;
            end
         end
         tkfr_pkg::ST_CMP: state_in = tkfr_pkg::ST_UPD;
         tkfr_pkg::ST_UPD: state_in = tkfr_pkg::ST_EMIT;
         tkfr_pkg::ST_EMIT: begin
            if (out_free && emit_last) begin
               state_in = tkfr_pkg::ST_IDLE;
            end
         end
         default: state_in = tkfr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      pop      = 1'b0;
      cmp_en   = 1'b0;
      upd_en   = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         tkfr_pkg::ST_IDLE: pop = head_valid;
         tkfr_pkg::ST_CMP:  cmp_en = 1'b1;
         tkfr_pkg::ST_UPD:  upd_en = 1'b1;
         tkfr_pkg::ST_EMIT: load_out = out_free;
         default: ;
      endcase
   end

   always_comb begin
      applied_in = applied_ff;
      emit_in    = emit_ff;
      if (upd_en) begin
         applied_in = consider;
         emit_in    = '0;
      end else if (load_out) begin
         emit_in = emit_ff + CNT_W'(1);
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tkfr_pkg::ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (upd_en && consider) begin
            fill_ff <= fill_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      applied_ff <= applied_in;
      emit_ff    <= emit_in;
      if (pop) begin
         cur_ff <= head_item;
      end
      if (cmp_en) begin
         id_eq_ff <= id_eq_in;
         gt_ff    <= gt_in;
         eq_ff    <= eq_in;
      end
      if (upd_en && consider) begin
         ids_ff    <= ids_in;
         counts_ff <= counts_in;
      end
      if (load_out) begin
         rsp_doc_ff     <= ids_ff[emit_ff[IDX_W-1:0]];
         rsp_cnt_ff     <= counts_ff[emit_ff[IDX_W-1:0]];
         rsp_pos_ff     <= tkfr_pkg::POS_W'(emit_ff);
         rsp_applied_ff <= applied_ff;
         rsp_last_ff    <= emit_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_rank_doc   = rsp_doc_ff;
   assign rsp_rank_count = rsp_cnt_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_applied    = rsp_applied_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

// ===== hdl/top_k_frequency_ranking.sv =====
// Top-K frequency ranking: keeps the K highest-frequency (doc id, count) pairs.
// Depends on tkfr_pkg, tkfr_queue and tkfr_engine.
//
// Usage:
//   req_*  : one request per (doc id, count) pair, valid/stall handshake.
//   rsp_*  : after every request the whole ranked list is sent, rank 0 first,
//            one response per entry, rsp_last on the final one.
//   csr_*  : write of keep_count (K); 0 acts as 1, values above MAX_KEEP
//            saturate. Write only while the block is idle.
// Flow: a request passes the queue and the engine's idle, compare and update
// states before its first response is loaded into the output register.
// Each request is finished before the next is popped: the compare and update
// steps, then one emitted entry per cycle while the response register is free.
// A two-entry queue holds requests while the engine works; req_stall rises
// when it is full.
// Reset: list empty, keep_count = 5, no response pending.
// rsp_stall holds the response register; the engine waits until it is free.
`timescale 1ns / 1ps
`default_nettype none

module top_k_frequency_ranking #(
   parameter int MAX_KEEP = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [tkfr_pkg::DATA_W-1:0]        req_doc_id,
   input  wire logic [tkfr_pkg::DATA_W-1:0]        req_count,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [tkfr_pkg::DATA_W-1:0]             rsp_rank_doc,
   output logic [tkfr_pkg::DATA_W-1:0]             rsp_rank_count,
   output logic [tkfr_pkg::POS_W-1:0]              rsp_position,
   output logic                                    rsp_applied,
   output logic                                    rsp_last,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tkfr_pkg::KEEP_W-1:0]        csr_keep_count
);

   localparam int CNT_W = $clog2(MAX_KEEP + 1);

   logic [tkfr_pkg::KEEP_W-1:0] keep_count_ff;
   logic [CNT_W-1:0]            keep_eff;
   tkfr_pkg::item_type          req_item;
   tkfr_pkg::item_type          head_item;
   logic                        head_valid;
   logic                        pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         keep_count_ff <= tkfr_pkg::KEEP_RESET;
      end else if (csr_valid && csr_ready) begin
         keep_count_ff <= csr_keep_count;
      end
   end

   always_comb begin
      priority if (keep_count_ff == '0) begin
         keep_eff = CNT_W'(1);
      end else if (32'(keep_count_ff) > 32'(MAX_KEEP)) begin
         keep_eff = CNT_W'(MAX_KEEP);
      end else begin
         keep_eff = CNT_W'(keep_count_ff);
      end
   end

   assign req_item.doc_id = req_doc_id;
   assign req_item.count  = req_count;

   tkfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_valid),
      .full       (req_stall),
      .push_item  (req_item),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop)
   );

   tkfr_engine #(
      .MAX_KEEP (MAX_KEEP)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .keep           (keep_eff),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_rank_doc   (rsp_rank_doc),
      .rsp_rank_count (rsp_rank_count),
      .rsp_position   (rsp_position),
      .rsp_applied    (rsp_applied),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/tkfr_rank_checker.sv =====
// Ranking predictor and response checker for top_k_frequency_ranking.
// Watches the req, rsp and csr channels; depends on tkfr_pkg only.
`timescale 1ns / 1ps

module tkfr_rank_checker #(
   parameter int LIST_DEPTH = 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic [tkfr_pkg::DATA_W-1:0]   req_doc_id,
   input  wire logic [tkfr_pkg::DATA_W-1:0]   req_count,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [tkfr_pkg::DATA_W-1:0]   rsp_rank_doc,
   input  wire logic [tkfr_pkg::DATA_W-1:0]   rsp_rank_count,
   input  wire logic [tkfr_pkg::POS_W-1:0]    rsp_position,
   input  wire logic                          rsp_applied,
   input  wire logic                          rsp_last,
   input  wire logic                          csr_valid,
   input  wire logic                          csr_ready,
   input  wire logic [tkfr_pkg::KEEP_W-1:0]   csr_keep_count,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 request_count,
   output int                                 result_count,
   output int                                 applied_count
);

   typedef struct {
      logic [tkfr_pkg::DATA_W-1:0] doc;
      logic [tkfr_pkg::DATA_W-1:0] cnt;
      logic [tkfr_pkg::POS_W-1:0]  pos;
      logic                        applied;
      logic                        last;
   } rank_entry_type;

   rank_entry_type              expected_ranks[$];
   logic [tkfr_pkg::DATA_W-1:0] list_ids[LIST_DEPTH];
   logic [tkfr_pkg::DATA_W-1:0] list_counts[LIST_DEPTH];
   int                          list_fill;
   logic [tkfr_pkg::KEEP_W-1:0] keep_reg;

   initial begin
      fail_count    = 0;
      request_count = 0;
      result_count  = 0;
      applied_count = 0;
      pending       = 0;
      list_fill     = 0;
      keep_reg      = tkfr_pkg::KEEP_RESET;
   end

   task automatic predict_ranking(input logic [tkfr_pkg::DATA_W-1:0] id,
                                  input logic [tkfr_pkg::DATA_W-1:0] cnt);
      int                          k;
      int                          n;
      int                          m;
      int                          j;
      bit                          taken;
      bit                          found;
      logic [tkfr_pkg::DATA_W-1:0] wid[LIST_DEPTH+1];
      logic [tkfr_pkg::DATA_W-1:0] wcnt[LIST_DEPTH+1];
      logic [tkfr_pkg::DATA_W-1:0] ci;
      logic [tkfr_pkg::DATA_W-1:0] di;
      rank_entry_type              e;
      k = (keep_reg == 0) ? 1 : int'(keep_reg);
      if (k > LIST_DEPTH) k = LIST_DEPTH;
      n = list_fill;
      taken = (n < k) || (n > 0 && cnt > list_counts[n-1]);
      if (taken) begin
         found = 0;
         for (int i = 0; i < n; i++) begin
            wid[i]  = list_ids[i];
            wcnt[i] = list_counts[i];
         end
         for (int i = 0; i < n; i++) begin
            if (!found && wid[i] == id) begin
               wcnt[i] = cnt;
               found   = 1;
            end
         end
         m = n;
         if (!found) begin
            wid[m]  = id;
            wcnt[m] = cnt;
            m++;
         end
         // stable insertion sort, highest count first
         for (int i = 1; i < m; i++) begin
            ci = wcnt[i];
            di = wid[i];
            j  = i;
            while (j > 0 && wcnt[j-1] < ci) begin
               wcnt[j] = wcnt[j-1];
               wid[j]  = wid[j-1];
               j--;
            end
            wcnt[j] = ci;
            wid[j]  = di;
         end
         if (m > k) m = k;
         for (int i = 0; i < m; i++) begin
            list_ids[i]    = wid[i];
            list_counts[i] = wcnt[i];
         end
         n = m;
         applied_count++;
      end
      list_fill = n;
      for (int i = 0; i < n; i++) begin
         e.doc     = list_ids[i];
         e.cnt     = list_counts[i];
         e.pos     = i[tkfr_pkg::POS_W-1:0];
         e.applied = taken;
         e.last    = (i == n - 1);
         expected_ranks.insert(expected_ranks.size(), e);
      end
   endtask

   task automatic check_field(input string name, input logic [tkfr_pkg::POS_W-1:0] pos,
                              input logic [tkfr_pkg::DATA_W-1:0] want,
                              input logic [tkfr_pkg::DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t ns: rank %0d %s expected 0x%08h actual 0x%08h",
                  $time, pos, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rank_entry_type e;
      if (reset) begin
         expected_ranks.delete();
         list_fill = 0;
         keep_reg  = tkfr_pkg::KEEP_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_ranks.size() == 0) begin
               $display({"%0t ns: unexpected response expected none",
                         " actual doc 0x%08h count 0x%08h"},
                        $time, rsp_rank_doc, rsp_rank_count);
               fail_count++;
            end else begin
               e = expected_ranks.pop_front();
               check_field("rank_doc", e.pos, e.doc, rsp_rank_doc);
               check_field("rank_count", e.pos, e.cnt, rsp_rank_count);
               check_field("position", e.pos, tkfr_pkg::DATA_W'(e.pos),
                           tkfr_pkg::DATA_W'(rsp_position));
               check_field("applied", e.pos, tkfr_pkg::DATA_W'(e.applied),
                           tkfr_pkg::DATA_W'(rsp_applied));
               check_field("last", e.pos, tkfr_pkg::DATA_W'(e.last),
                           tkfr_pkg::DATA_W'(rsp_last));
            end
         end
         if (csr_valid && csr_ready) keep_reg = csr_keep_count;
         if (req_valid && !req_stall) begin
            request_count++;
            predict_ranking(req_doc_id, req_count);
         end
      end
      pending <= expected_ranks.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for top_k_frequency_ranking: clock, reset, request stimulus,
// keep_count writes and response back-pressure. Depends on tkfr_pkg and tkfr_rank_checker.
`timescale 1ns / 1ps

module tb_top;

   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS   = 40;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic [tkfr_pkg::DATA_W-1:0]   req_doc_id;
   logic [tkfr_pkg::DATA_W-1:0]   req_count;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [tkfr_pkg::DATA_W-1:0]   rsp_rank_doc;
   logic [tkfr_pkg::DATA_W-1:0]   rsp_rank_count;
   logic [tkfr_pkg::POS_W-1:0]    rsp_position;
   logic                          rsp_applied;
   logic                          rsp_last;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [tkfr_pkg::KEEP_W-1:0]   csr_keep_count;

   int fail_count;
   int pending;
   int request_count;
   int result_count;
   int applied_count;
   int keep_writes;
   int sender_idle_pct;
   int receiver_idle_pct;
   bit long_hold;

   top_k_frequency_ranking dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_doc_id(req_doc_id),
      .req_count(req_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_rank_doc(rsp_rank_doc),
      .rsp_rank_count(rsp_rank_count),
      .rsp_position(rsp_position),
      .rsp_applied(rsp_applied),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_keep_count(csr_keep_count)
   );

   tkfr_rank_checker rank_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_doc_id(req_doc_id),
      .req_count(req_count),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_rank_doc(rsp_rank_doc),
      .rsp_rank_count(rsp_rank_count),
      .rsp_position(rsp_position),
      .rsp_applied(rsp_applied),
      .rsp_last(rsp_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_keep_count(csr_keep_count),
      .fail_count(fail_count),
      .pending(pending),
      .request_count(request_count),
      .result_count(result_count),
      .applied_count(applied_count)
   );

   initial clock = 1'b0;
   always #2 clock = ~clock;

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // response side: random stalls, plus one long hold on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end
         rsp_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
      end
   end

   task automatic send_pair(input logic [tkfr_pkg::DATA_W-1:0] id,
                            input logic [tkfr_pkg::DATA_W-1:0] cnt);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_doc_id <= id;
      req_count  <= cnt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(input logic [tkfr_pkg::KEEP_W-1:0] value);
      wait_drained();
      csr_valid      <= 1'b1;
      csr_keep_count <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      keep_writes++;
   endtask

   initial begin
      logic [tkfr_pkg::DATA_W-1:0] id;
      logic [tkfr_pkg::DATA_W-1:0] cnt;
      logic [tkfr_pkg::DATA_W-1:0] drift;
      int                          sel;
      bit                          wide;
      keep_writes       = 0;
      sender_idle_pct   = 25;
      receiver_idle_pct = 25;
      long_hold         = 1'b0;
      drift             = 0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_doc_id     <= '0;
      req_count      <= '0;
      csr_valid      <= 1'b0;
      csr_keep_count <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, ties, updates up and down, ignored offers
      send_pair(32'h0000_0000, 32'h0000_0000);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_pair(32'hFFFF_FFFF, 32'h0000_0000);
      send_pair(32'hFFFF_FFFF, 32'h0000_0000);
      send_pair(32'h0000_0000, 32'd7);
      send_pair(32'd10, 32'd100);
      send_pair(32'd11, 32'd100);
      send_pair(32'd12, 32'd100);
      send_pair(32'd20, 32'd0);
      send_pair(32'd21, 32'd50);
      send_pair(32'd12, 32'd1);
      send_pair(32'd12, 32'd8);
      write_keep(4'd8);
      send_pair(32'd30, 32'd3);
      send_pair(32'd31, 32'd2);
      send_pair(32'd32, 32'd1);
      // keep lowered below the fill level
      write_keep(4'd2);
      send_pair(32'd40, 32'd0);
      send_pair(32'd41, 32'd5);
      write_keep(4'd0);
      send_pair(32'd50, 32'd200);
      send_pair(32'd51, 32'd150);
      write_keep(4'd15);
      send_pair(32'd60, 32'd300);
      send_pair(32'd61, 32'd300);
      send_pair(32'd50, 32'd299);

      for (int p = 0; p < 5; p++) begin
         write_keep(p == 4 ? 4'd8 : 4'($urandom_range(0, 15)));
         wide              = (p == 4);
         sender_idle_pct   = (p == 1) ? 0 : 25;
         receiver_idle_pct = (p == 1) ? 0 : 25;
         if (p == 2) long_hold = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 3 && n == PHASE_ITEMS / 2) wait_drained();
            drift = drift + $urandom_range(0, 3);
            sel   = $urandom_range(0, 99);
            if (wide && sel < 40) cnt = $urandom;
            else if (sel < 12) cnt = $urandom_range(0, 3);
            else cnt = drift + $urandom_range(0, 40) + 300;
            sel = $urandom_range(0, 99);
            if (sel < 70) id = $urandom_range(1, 12);
            else if (sel < 90) id = $urandom;
            else id = (sel < 95) ? 32'h0000_0000 : 32'hFFFF_FFFF;
            send_pair(id, cnt);
         end
      end

      wait_drained();
      $display("Covered %0d requests (%0d changed the list), %0d ranked responses,",
               request_count, applied_count, result_count);
      $display("%0d keep_count writes, a long response hold and drained pauses.", keep_writes);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
